>>> rtl/button_gesture_classifier_top_defines.svh
// ----------------------------------------------------------------------------
// button gesture classifier assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_CLASSIFIER_TOP_DEFINES_SVH
`define BUTTON_GESTURE_CLASSIFIER_TOP_DEFINES_SVH

// same-cycle implication under synchronous active-low reset
`define BGC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous active-low reset
`define BGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg
// types, codes and defaults shared by the button gesture classifier
// ----------------------------------------------------------------------------
package bgc_pkg;

    localparam int BUTTONS_DEF = 4;
    localparam int MAX_RESULTS = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam int CMD_W     = 2;
    localparam int BTN_W     = 3;
    localparam int TIME_W    = 32;
    localparam int GEST_W    = 2;
    localparam int TALLY_W   = 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_PRESS   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd2;

    localparam logic [GEST_W-1:0] GEST_SHORT  = 2'd0;
    localparam logic [GEST_W-1:0] GEST_LONG   = 2'd1;
    localparam logic [GEST_W-1:0] GEST_DOUBLE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] DOUBLE_RST   = 16'd300;
    localparam logic [CFG_W-1:0] LONG_RST     = 16'd1000;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_TICK    = 2'd2
    } t_kind;

    // classified request handed from front to back, button as 0-based index
    typedef struct packed {
        t_kind             kind;
        logic [BTN_W-1:0]  btn;
        logic [TIME_W-1:0] stamp;
    } t_req;

    typedef struct packed {
        logic [BTN_W-1:0]  button_id;
        logic [GEST_W-1:0] gesture;
        logic [TIME_W-1:0] event_time;
        logic              last;
    } t_res;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
    } t_cfg_wr;

endpackage

>>> rtl/bgc_in_if.sv
// ----------------------------------------------------------------------------
// bgc_in_if
// input request channel: command, button and timestamp
// ----------------------------------------------------------------------------
interface bgc_in_if;
    logic                         valid;
    logic                         ready;
    logic [bgc_pkg::CMD_W-1:0]    command;
    logic [bgc_pkg::BTN_W-1:0]    button;
    logic [bgc_pkg::TIME_W-1:0]   timestamp;

    modport source (output valid, output command, output button, output timestamp,
                    input ready);
    modport sink   (input valid, input command, input button, input timestamp,
                    output ready);
endinterface

>>> rtl/bgc_out_if.sv
// ----------------------------------------------------------------------------
// bgc_out_if
// result channel: button, gesture, time and last flag
// ----------------------------------------------------------------------------
interface bgc_out_if;
    logic                         valid;
    logic                         ready;
    logic [bgc_pkg::BTN_W-1:0]    button_id;
    logic [bgc_pkg::GEST_W-1:0]   gesture;
    logic [bgc_pkg::TIME_W-1:0]   event_time;
    logic                         last;

    modport source (output valid, output button_id, output gesture, output event_time,
                    output last, input ready);
    modport sink   (input valid, input button_id, input gesture, input event_time,
                    input last, output ready);
endinterface

>>> rtl/button_gesture_classifier_top.sv
// ----------------------------------------------------------------------------
// button_gesture_classifier_top
// short, long and double press detection for up to seven buttons
// ----------------------------------------------------------------------------
// Requests are taken into a two-entry queue whenever it has room, so the
// input side keeps moving while a result waits on the output. The executor
// handles one queued request at a time against a single-port per-button
// state file: a press updates that file, a release that reports passes
// through the flush state and waits on the output; a tick walks the buttons
// one per cycle while no hit waits on a stalled output, for up to four
// results. A result is held back one step so the final one can carry last.
module button_gesture_classifier_top #(
    parameter int BUTTONS = bgc_pkg::BUTTONS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bgc_in_if.sink                          i_req,
    bgc_out_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [bgc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bgc_pkg::CFG_W-1:0]       i_cfg_data
);
    bgc_pkg::t_req    head;
    logic             head_v;
    logic             pop;
    bgc_pkg::t_cfg_wr cfg;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    bgc_front #(
        .BUTTONS (BUTTONS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .o_head   (head),
        .o_head_v (head_v),
        .i_pop    (pop)
    );

    bgc_back #(
        .BUTTONS (BUTTONS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_head   (head),
        .i_head_v (head_v),
        .o_pop    (pop),
        .o_res    (o_res)
    );

endmodule

>>> rtl/bgc_front.sv
// ----------------------------------------------------------------------------
// bgc_front
// accepts requests, drops meaningless ones and queues the rest for the back
// ----------------------------------------------------------------------------
module bgc_front #(
    parameter int BUTTONS = bgc_pkg::BUTTONS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bgc_in_if.sink        i_req,
    output bgc_pkg::t_req o_head,
    output logic          o_head_v,
    input  logic          i_pop
);
    localparam int QW = (bgc_pkg::QUEUE_DEPTH > 1) ? $clog2(bgc_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(bgc_pkg::QUEUE_DEPTH + 1);

    bgc_pkg::t_req r_q [bgc_pkg::QUEUE_DEPTH];
    logic [QW-1:0] r_wp;
    logic [QW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    logic          btn_ok;
    logic          keep;
    logic          push;
    logic          pop;
    bgc_pkg::t_req entry;

    assign btn_ok = (i_req.button != '0) &&
                    (i_req.button <= bgc_pkg::BTN_W'(BUTTONS));

    always_comb begin
        keep       = 1'b0;
        entry.kind = bgc_pkg::KIND_TICK;
        case (i_req.command)
            bgc_pkg::CMD_PRESS: begin
                keep       = btn_ok;
                entry.kind = bgc_pkg::KIND_PRESS;
            end
            bgc_pkg::CMD_RELEASE: begin
                keep       = btn_ok;
                entry.kind = bgc_pkg::KIND_RELEASE;
            end
            bgc_pkg::CMD_TICK: begin
                keep       = 1'b1;
                entry.kind = bgc_pkg::KIND_TICK;
            end
            default: begin
                keep       = 1'b0;
                entry.kind = bgc_pkg::KIND_TICK;
            end
        endcase
        entry.btn   = i_req.button - bgc_pkg::BTN_W'(1);
        entry.stamp = i_req.timestamp;
    end

    assign i_req.ready = (r_cnt != CW'(bgc_pkg::QUEUE_DEPTH));
    // unknown commands and presses or releases of bad buttons are taken but never queued
    assign push        = i_req.valid && i_req.ready && keep;
    assign pop         = i_pop && o_head_v;
    assign o_head_v    = (r_cnt != '0);
    assign o_head      = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QW'(bgc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + QW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == QW'(bgc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + QW'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= entry;
        end
    end

endmodule

>>> rtl/bgc_back.sv
// ----------------------------------------------------------------------------
// bgc_back
// per-button state, request execution, tick scan and result register
// ----------------------------------------------------------------------------
module bgc_back #(
    parameter int BUTTONS = bgc_pkg::BUTTONS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bgc_pkg::t_cfg_wr i_cfg,
    input  bgc_pkg::t_req    i_head,
    input  logic             i_head_v,
    output logic             o_pop,
    bgc_out_if.source        o_res
);
    localparam int IW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int NW = $clog2(bgc_pkg::MAX_RESULTS + 1);
    localparam int TW = bgc_pkg::TIME_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } t_state;

    logic [bgc_pkg::CFG_W-1:0]   r_deb;
    logic [bgc_pkg::CFG_W-1:0]   r_dbl;
    logic [bgc_pkg::CFG_W-1:0]   r_lp;

    logic                        r_held  [BUTTONS];
    logic                        r_long  [BUTTONS];
    logic [bgc_pkg::TALLY_W-1:0] r_tally [BUTTONS];
    logic [TW-1:0]               r_hs    [BUTTONS];
    logic [TW-1:0]               r_pp    [BUTTONS];

    t_state                      r_state, n_state;
    logic [IW-1:0]               r_idx, n_idx;
    logic [NW-1:0]               r_n, n_n;
    logic [TW-1:0]               r_t, n_t;
    bgc_pkg::t_res               r_pend, n_pend;
    logic                        r_pend_v, n_pend_v;
    bgc_pkg::t_res               r_out;
    logic                        r_out_v;

    logic [IW-1:0]               a;
    logic [TW-1:0]               tc;
    logic                        cur_held, cur_long;
    logic [bgc_pkg::TALLY_W-1:0] cur_tally;
    logic [TW-1:0]               cur_hs, cur_pp;
    logic [TW-1:0]               since_pp, since_hs;
    logic [TW-1:0]               deb, dbl, lp;
    logic                        can_push, push, push_last;
    logic                        hit_long, hit_short, hit;
    logic                        we;
    logic                        w_held, w_long;
    logic [bgc_pkg::TALLY_W-1:0] w_tally;
    logic [TW-1:0]               w_hs, w_pp;

    assign a         = (r_state == ST_SCAN) ? r_idx : i_head.btn[IW-1:0];
    assign tc        = (r_state == ST_SCAN) ? r_t : i_head.stamp;
    assign cur_held  = r_held[a];
    assign cur_long  = r_long[a];
    assign cur_tally = r_tally[a];
    assign cur_hs    = r_hs[a];
    assign cur_pp    = r_pp[a];
    assign since_pp  = tc - cur_pp;
    assign since_hs  = tc - cur_hs;
    assign deb       = TW'(r_deb);
    assign dbl       = TW'(r_dbl);
    assign lp        = TW'(r_lp);
    assign can_push  = !r_out_v || o_res.ready;

    assign hit_long  = cur_held && !cur_long && (since_hs >= lp);
    assign hit_short = !cur_held && (cur_tally == bgc_pkg::TALLY_W'(1)) && (since_pp >= dbl);
    assign hit       = hit_long || hit_short;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_n       = r_n;
        n_t       = r_t;
        n_pend    = r_pend;
        n_pend_v  = r_pend_v;
        o_pop     = 1'b0;
        push      = 1'b0;
        push_last = 1'b0;
        we        = 1'b0;
        w_held    = cur_held;
        w_long    = cur_long;
        w_tally   = cur_tally;
        w_hs      = cur_hs;
        w_pp      = cur_pp;
        case (r_state)
            ST_IDLE: begin
                if (i_head_v) begin
                    o_pop = 1'b1;
                    case (i_head.kind)
                        bgc_pkg::KIND_PRESS: begin
                            if (!cur_held && since_pp >= deb) begin
                                we     = 1'b1;
                                w_held = 1'b1;
                                w_long = 1'b0;
                                w_hs   = tc;
                                w_pp   = tc;
                                if (since_pp < dbl) begin
                                    // tally saturates at its top value
                                    w_tally = (&cur_tally) ? cur_tally
                                            : cur_tally + bgc_pkg::TALLY_W'(1);
                                end else begin
                                    w_tally = bgc_pkg::TALLY_W'(1);
                                end
                            end
                        end
                        bgc_pkg::KIND_RELEASE: begin
                            if (cur_held) begin
                                we     = 1'b1;
                                w_held = 1'b0;
                                n_pend.button_id  = i_head.btn + bgc_pkg::BTN_W'(1);
                                n_pend.event_time = tc;
                                n_pend.last       = 1'b1;
                                n_pend.gesture    = bgc_pkg::GEST_LONG;
                                if (!cur_long) begin
                                    if (cur_tally >= bgc_pkg::TALLY_W'(2)) begin
                                        w_tally        = '0;
                                        n_pend.gesture = bgc_pkg::GEST_DOUBLE;
                                        n_pend_v       = 1'b1;
                                        n_state        = ST_FLUSH;
                                    end else if (since_hs >= lp) begin
                                        n_pend_v = 1'b1;
                                        n_state  = ST_FLUSH;
                                    end
                                end
                            end
                        end
                        bgc_pkg::KIND_TICK: begin
                            n_t     = i_head.stamp;
                            n_idx   = '0;
                            n_n     = '0;
                            n_state = ST_SCAN;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // a new hit must wait while the held result cannot leave
                if (!(hit && r_pend_v && !can_push)) begin
                    if (hit) begin
                        we = 1'b1;
                        if (hit_long) begin
                            w_long = 1'b1;
                        end else begin
                            w_tally = '0;
                        end
                        push              = r_pend_v;
                        n_pend.button_id  = bgc_pkg::BTN_W'(r_idx) + bgc_pkg::BTN_W'(1);
                        n_pend.gesture    = hit_long ? bgc_pkg::GEST_LONG : bgc_pkg::GEST_SHORT;
                        n_pend.event_time = r_t;
                        n_pend.last       = 1'b0;
                        n_pend_v          = 1'b1;
                        n_n               = r_n + NW'(1);
                    end
                    if (r_idx == IW'(BUTTONS - 1) ||
                        (hit && r_n == NW'(bgc_pkg::MAX_RESULTS - 1))) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = ST_IDLE;
                end else if (can_push) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    n_pend_v  = 1'b0;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_idx    <= '0;
            r_n      <= '0;
            r_deb    <= bgc_pkg::DEBOUNCE_RST;
            r_dbl    <= bgc_pkg::DOUBLE_RST;
            r_lp     <= bgc_pkg::LONG_RST;
        end else begin
            r_state  <= n_state;
            r_pend_v <= n_pend_v;
            r_idx    <= n_idx;
            r_n      <= n_n;
            if (push) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    bgc_pkg::CFG_DEBOUNCE: r_deb <= i_cfg.data;
                    bgc_pkg::CFG_DOUBLE:   r_dbl <= i_cfg.data;
                    bgc_pkg::CFG_LONG:     r_lp  <= i_cfg.data;
                    default:               r_deb <= r_deb;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t    <= n_t;
        r_pend <= n_pend;
        if (push) begin
            r_out <= {r_pend.button_id, r_pend.gesture, r_pend.event_time, push_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < BUTTONS; k++) begin
                r_held[k]  <= 1'b0;
                r_long[k]  <= 1'b0;
                r_tally[k] <= '0;
                r_hs[k]    <= '0;
                r_pp[k]    <= '0;
            end
        end else if (we) begin
            r_held[a]  <= w_held;
            r_long[a]  <= w_long;
            r_tally[a] <= w_tally;
            r_hs[a]    <= w_hs;
            r_pp[a]    <= w_pp;
        end
    end

    assign o_res.valid      = r_out_v;
    assign o_res.button_id  = r_out.button_id;
    assign o_res.gesture    = r_out.gesture;
    assign o_res.event_time = r_out.event_time;
    assign o_res.last       = r_out.last;

endmodule

>>> rtl/bgc_checker.sv
// ----------------------------------------------------------------------------
// bgc_checker
// port-level checks on the result channel of the classifier
// ----------------------------------------------------------------------------
`include "button_gesture_classifier_top_defines.svh"

module bgc_checker #(
    parameter int BUTTONS = bgc_pkg::BUTTONS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          i_ready,
    input logic [bgc_pkg::BTN_W-1:0]     i_button_id,
    input logic [bgc_pkg::GEST_W-1:0]    i_gesture,
    input logic [bgc_pkg::TIME_W-1:0]    i_event_time,
    input logic                          i_last
);
    // a stalled result stays put
    `BGC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_button_id) && $stable(i_gesture) && $stable(i_event_time) && $stable(i_last), "stalled result changed")

    `BGC_ASSERT_SAME(a_btn_range, i_clk, i_rst_n, i_valid, (i_button_id != '0) && (i_button_id <= bgc_pkg::BTN_W'(BUTTONS)), "button id out of range")

    `BGC_ASSERT_SAME(a_gest_code, i_clk, i_rst_n, i_valid, (i_gesture == bgc_pkg::GEST_SHORT) || (i_gesture == bgc_pkg::GEST_LONG) || (i_gesture == bgc_pkg::GEST_DOUBLE), "bad gesture code")

    // a double press only comes from a release, which reports alone
    `BGC_ASSERT_SAME(a_double_last, i_clk, i_rst_n, i_valid && (i_gesture == bgc_pkg::GEST_DOUBLE), i_last, "double press without last")

endmodule

bind button_gesture_classifier_top bgc_checker #(
    .BUTTONS (BUTTONS)
) u_bgc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_res.valid),
    .i_ready      (o_res.ready),
    .i_button_id  (o_res.button_id),
    .i_gesture    (o_res.gesture),
    .i_event_time (o_res.event_time),
    .i_last       (o_res.last)
);

>>> test/tb_button_gesture_classifier_top.sv
// ----------------------------------------------------------------------------
// tb_button_gesture_classifier_top
// self-checking bench for the four-button gesture classifier
// ----------------------------------------------------------------------------
// Press, release and tick requests go in through a queue-fed driver. Each
// accepted request runs through a bench-side gesture model, and the gestures
// that come out of the block are compared in order against that model. A
// directed opener is followed by random click, chord and noise sequences
// under several debounce, double-click and long-press settings, with random
// stalls on one or both channels in every phase but the final one.
// ----------------------------------------------------------------------------
module tb_button_gesture_classifier_top;

    localparam int NUM_BUTTONS = bgc_pkg::BUTTONS_DEF;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [bgc_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [bgc_pkg::CMD_W-1:0]  command;
        logic [bgc_pkg::BTN_W-1:0]  button;
        logic [bgc_pkg::TIME_W-1:0] stamp;
    } t_button_req;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [bgc_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [bgc_pkg::CFG_W-1:0] i_cfg_data;

    bgc_in_if req_if();
    bgc_out_if res_if();

    button_gesture_classifier_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // gesture model state
    logic [bgc_pkg::CFG_W-1:0]   debounce_cfg;
    logic [bgc_pkg::CFG_W-1:0]   dbl_window_cfg;
    logic [bgc_pkg::CFG_W-1:0]   long_hold_cfg;
    logic                        btn_held      [NUM_BUTTONS];
    logic                        long_reported [NUM_BUTTONS];
    logic [bgc_pkg::TALLY_W-1:0] tally         [NUM_BUTTONS];
    logic [bgc_pkg::TIME_W-1:0]  hold_t0       [NUM_BUTTONS];
    logic [bgc_pkg::TIME_W-1:0]  last_press_t  [NUM_BUTTONS];

    t_button_req pending_reqs[$];
    bgc_pkg::t_res exp_gestures[$];

    bit src_idle;
    bit snk_idle;
    int src_gap;
    int snk_stall;
    int errors;
    int reqs_accepted;
    int queued_total;
    int short_seen;
    int long_seen;
    int double_seen;
    logic [bgc_pkg::TIME_W-1:0] now_ms;
    t_button_req next_req;
    bgc_pkg::t_res want;

    function automatic bgc_pkg::t_res make_gesture(int idx, logic [bgc_pkg::GEST_W-1:0] kind,
                                                   logic [bgc_pkg::TIME_W-1:0] ts);
        bgc_pkg::t_res r;
        r.button_id = bgc_pkg::BTN_W'(idx + 1);
        r.gesture = kind;
        r.event_time = ts;
        r.last = 1'b0;
        return r;
    endfunction

    // works out the gestures caused by one accepted request
    function automatic void predict_gestures(logic [bgc_pkg::CMD_W-1:0] cmd,
                                             logic [bgc_pkg::BTN_W-1:0] btn,
                                             logic [bgc_pkg::TIME_W-1:0] ts);
        int idx;
        int i;
        logic [bgc_pkg::TIME_W-1:0] since;
        bgc_pkg::t_res r;
        bgc_pkg::t_res found[$];
        if (cmd == bgc_pkg::CMD_PRESS || cmd == bgc_pkg::CMD_RELEASE) begin
            if (btn < 1 || btn > NUM_BUTTONS) return;
            idx = btn - 1;
            if (cmd == bgc_pkg::CMD_PRESS) begin
                since = ts - last_press_t[idx];
                if (btn_held[idx] || since < bgc_pkg::TIME_W'(debounce_cfg)) return;
                btn_held[idx] = 1'b1;
                hold_t0[idx] = ts;
                long_reported[idx] = 1'b0;
                if (since < bgc_pkg::TIME_W'(dbl_window_cfg)) begin
                    if (tally[idx] != 2'd3) tally[idx] = tally[idx] + 2'd1;
                end else begin
                    tally[idx] = 2'd1;
                end
                last_press_t[idx] = ts;
                return;
            end
            if (!btn_held[idx]) return;
            btn_held[idx] = 1'b0;
            if (long_reported[idx]) return;
            since = ts - hold_t0[idx];
            if (tally[idx] >= 2'd2) begin
                tally[idx] = 2'd0;
                r = make_gesture(idx, bgc_pkg::GEST_DOUBLE, ts);
            end else if (since >= bgc_pkg::TIME_W'(long_hold_cfg)) begin
                r = make_gesture(idx, bgc_pkg::GEST_LONG, ts);
            end else begin
                return;
            end
            r.last = 1'b1;
            exp_gestures.push_back(r);
        end else if (cmd == bgc_pkg::CMD_TICK) begin
            for (i = 0; i < NUM_BUTTONS && found.size() < bgc_pkg::MAX_RESULTS; i++) begin
                if (btn_held[i] && !long_reported[i]) begin
                    since = ts - hold_t0[i];
                    if (since >= bgc_pkg::TIME_W'(long_hold_cfg)) begin
                        long_reported[i] = 1'b1;
                        found.push_back(make_gesture(i, bgc_pkg::GEST_LONG, ts));
                    end
                end
                if (found.size() < bgc_pkg::MAX_RESULTS && !btn_held[i] && tally[i] == 2'd1) begin
                    since = ts - last_press_t[i];
                    if (since >= bgc_pkg::TIME_W'(dbl_window_cfg)) begin
                        tally[i] = 2'd0;
                        found.push_back(make_gesture(i, bgc_pkg::GEST_SHORT, ts));
                    end
                end
            end
            if (found.size() != 0) found[found.size() - 1].last = 1'b1;
            foreach (found[k]) exp_gestures.push_back(found[k]);
        end
    endfunction

    function automatic void add_req(logic [bgc_pkg::CMD_W-1:0] cmd,
                                    logic [bgc_pkg::BTN_W-1:0] btn,
                                    logic [bgc_pkg::TIME_W-1:0] ts);
        t_button_req q;
        q.command = cmd;
        q.button = btn;
        q.stamp = ts;
        pending_reqs.push_back(q);
        queued_total++;
    endfunction

    // delay mostly around a threshold, on both sides of it
    function automatic int unsigned spread(int unsigned ms);
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, ms / 2);
            1: return ms - ms / 8 + $urandom_range(0, ms / 4 + 2);
            2: return $urandom_range(ms, 2 * ms + 10);
            default: return $urandom_range(0, 3 * ms + 20);
        endcase
    endfunction

    function automatic void gen_sequences(int n);
        int stop_at;
        int b;
        int presses;
        int k;
        logic [NUM_BUTTONS-1:0] mask;
        stop_at = queued_total + n;
        while (queued_total < stop_at) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8: begin
                    // single, double or triple click on one button
                    b = $urandom_range(1, NUM_BUTTONS);
                    presses = $urandom_range(1, 3);
                    for (k = 0; k < presses; k++) begin
                        add_req(bgc_pkg::CMD_PRESS, bgc_pkg::BTN_W'(b), now_ms);
                        now_ms += $urandom_range(0, 1) ? $urandom_range(0, dbl_window_cfg / 3 + 2)
                                                       : spread(long_hold_cfg);
                        if ($urandom_range(0, 3) == 0) add_req(bgc_pkg::CMD_TICK, 3'd0, now_ms);
                        add_req(bgc_pkg::CMD_RELEASE, bgc_pkg::BTN_W'(b), now_ms);
                        now_ms += $urandom_range(0, 1) ? $urandom_range(0, dbl_window_cfg / 2 + 2)
                                                       : spread(dbl_window_cfg);
                    end
                    add_req(bgc_pkg::CMD_TICK, bgc_pkg::BTN_W'($urandom_range(0, 7)), now_ms);
                end
                9, 10, 11: begin
                    // several buttons held together
                    mask = NUM_BUTTONS'($urandom_range(1, (1 << NUM_BUTTONS) - 1));
                    for (k = 0; k < NUM_BUTTONS; k++) begin
                        if (mask[k]) begin
                            add_req(bgc_pkg::CMD_PRESS, bgc_pkg::BTN_W'(k + 1), now_ms);
                            now_ms += $urandom_range(0, 3);
                        end
                    end
                    now_ms += spread(long_hold_cfg);
                    add_req(bgc_pkg::CMD_TICK, 3'd0, now_ms);
                    if ($urandom_range(0, 1) == 1) begin
                        now_ms += spread(dbl_window_cfg);
                        add_req(bgc_pkg::CMD_TICK, 3'd0, now_ms);
                    end
                    for (k = NUM_BUTTONS - 1; k >= 0; k--) begin
                        if (mask[k]) begin
                            add_req(bgc_pkg::CMD_RELEASE, bgc_pkg::BTN_W'(k + 1), now_ms);
                            now_ms += $urandom_range(0, 5);
                        end
                    end
                    now_ms += spread(dbl_window_cfg);
                    add_req(bgc_pkg::CMD_TICK, 3'd0, now_ms);
                end
                12, 13, 14: begin
                    now_ms += spread(dbl_window_cfg);
                    add_req(bgc_pkg::CMD_TICK, bgc_pkg::BTN_W'($urandom_range(0, 7)), now_ms);
                end
                15, 16, 17: begin
                    add_req(bgc_pkg::CMD_W'($urandom_range(0, 3)),
                            bgc_pkg::BTN_W'($urandom_range(0, 7)),
                            $urandom_range(0, 1) ? now_ms : bgc_pkg::TIME_W'($urandom));
                end
                18: now_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * long_hold_cfg + 100);
                default: now_ms += $urandom;
            endcase
        end
    endfunction

    task automatic write_cfg(input logic [bgc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bgc_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            bgc_pkg::CFG_DEBOUNCE: debounce_cfg = val;
            bgc_pkg::CFG_DOUBLE:   dbl_window_cfg = val;
            bgc_pkg::CFG_LONG:     long_hold_cfg = val;
            default: ;
        endcase
    endtask

    task automatic set_timing(input logic [bgc_pkg::CFG_W-1:0] db,
                              input logic [bgc_pkg::CFG_W-1:0] dc,
                              input logic [bgc_pkg::CFG_W-1:0] lp);
        write_cfg(bgc_pkg::CFG_DEBOUNCE, db);
        write_cfg(bgc_pkg::CFG_DOUBLE, dc);
        write_cfg(bgc_pkg::CFG_LONG, lp);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // waits until every request is taken and every gesture is back,
    // then lets requests without a gesture finish inside the block
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || req_if.valid || exp_gestures.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [bgc_pkg::CFG_W-1:0] db,
                             input logic [bgc_pkg::CFG_W-1:0] dc,
                             input logic [bgc_pkg::CFG_W-1:0] lp, input bit src_on,
                             input bit snk_on, input int n);
        set_timing(db, dc, lp);
        src_idle = src_on;
        snk_idle = snk_on;
        gen_sequences(n);
        wait_drained();
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            src_gap = 0;
        end else if (!req_if.valid || req_if.ready) begin
            if (src_gap > 0) begin
                src_gap--;
                req_if.valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                next_req = pending_reqs.pop_front();
                req_if.valid <= 1'b1;
                req_if.command <= next_req.command;
                req_if.button <= next_req.button;
                req_if.timestamp <= next_req.stamp;
                if (src_idle && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 17);
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // result sink stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            snk_stall = 0;
        end else if (snk_stall > 0) begin
            snk_stall--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            if (snk_idle && $urandom_range(0, 7) == 0) snk_stall = $urandom_range(1, 17);
        end
    end

    // every accepted request updates the model
    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready) begin
            predict_gestures(req_if.command, req_if.button, req_if.timestamp);
            reqs_accepted++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (exp_gestures.size() == 0) begin
                errors++;
                $display({"%0t: unexpected gesture: expected none, ",
                          "got button %0d gesture %0d time %h last %0b"},
                         $time, res_if.button_id, res_if.gesture, res_if.event_time,
                         res_if.last);
            end else begin
                want = exp_gestures.pop_front();
                if (res_if.button_id !== want.button_id || res_if.gesture !== want.gesture ||
                    res_if.event_time !== want.event_time || res_if.last !== want.last) begin
                    errors++;
                    $display({"%0t: gesture mismatch: expected button %0d gesture %0d ",
                              "time %h last %0b, got button %0d gesture %0d time %h last %0b"},
                             $time, want.button_id, want.gesture, want.event_time, want.last,
                             res_if.button_id, res_if.gesture, res_if.event_time,
                             res_if.last);
                end
                case (want.gesture)
                    bgc_pkg::GEST_SHORT:  short_seen++;
                    bgc_pkg::GEST_LONG:   long_seen++;
                    bgc_pkg::GEST_DOUBLE: double_seen++;
                    default: ;
                endcase
            end
        end
    end

    initial begin
        #3000000;
        $display("%0t: run did not finish in time", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = bgc_pkg::CFG_DEBOUNCE;
        i_cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.command = bgc_pkg::CMD_PRESS;
        req_if.button = '0;
        req_if.timestamp = '0;
        res_if.ready = 1'b0;
        debounce_cfg = bgc_pkg::DEBOUNCE_RST;
        dbl_window_cfg = bgc_pkg::DOUBLE_RST;
        long_hold_cfg = bgc_pkg::LONG_RST;
        foreach (btn_held[i]) begin
            btn_held[i] = 1'b0;
            long_reported[i] = 1'b0;
            tally[i] = '0;
            hold_t0[i] = '0;
            last_press_t[i] = '0;
        end
        src_idle = 1'b1;
        snk_idle = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset timing: drops, ignored requests, double press, four long presses at once
        add_req(bgc_pkg::CMD_PRESS, 3'd1, 32'd10);        // too soon after reset
        add_req(CMD_UNUSED, 3'd1, 32'd20);
        add_req(bgc_pkg::CMD_PRESS, 3'd0, 32'd500);
        add_req(bgc_pkg::CMD_RELEASE, 3'd7, 32'd500);
        add_req(bgc_pkg::CMD_RELEASE, 3'd2, 32'd510);     // button already up
        add_req(bgc_pkg::CMD_PRESS, 3'd1, 32'd1000);
        add_req(bgc_pkg::CMD_PRESS, 3'd1, 32'd1010);      // already down
        add_req(bgc_pkg::CMD_RELEASE, 3'd1, 32'd1100);
        add_req(bgc_pkg::CMD_TICK, 3'd0, 32'd1200);
        add_req(bgc_pkg::CMD_PRESS, 3'd1, 32'd1250);
        add_req(bgc_pkg::CMD_RELEASE, 3'd1, 32'd1300);
        add_req(bgc_pkg::CMD_PRESS, 3'd1, 32'd2000);
        add_req(bgc_pkg::CMD_PRESS, 3'd2, 32'd2000);
        add_req(bgc_pkg::CMD_PRESS, 3'd3, 32'd2000);
        add_req(bgc_pkg::CMD_PRESS, 3'd4, 32'd2000);
        add_req(bgc_pkg::CMD_TICK, 3'd0, 32'd3000);
        add_req(bgc_pkg::CMD_RELEASE, 3'd4, 32'd3100);    // long press already reported
        wait_drained();

        // no debounce, wide window, short hold: release-time long and tally saturation
        set_timing(16'd0, 16'd65535, 16'd20);
        add_req(bgc_pkg::CMD_PRESS, 3'd4, 32'd100000);
        add_req(bgc_pkg::CMD_RELEASE, 3'd4, 32'd100030);
        add_req(bgc_pkg::CMD_PRESS, 3'd4, 32'd100040);
        add_req(bgc_pkg::CMD_TICK, 3'd0, 32'd100070);
        add_req(bgc_pkg::CMD_RELEASE, 3'd4, 32'd100075);
        add_req(bgc_pkg::CMD_PRESS, 3'd4, 32'd100080);
        add_req(bgc_pkg::CMD_TICK, 3'd0, 32'd100110);
        add_req(bgc_pkg::CMD_RELEASE, 3'd4, 32'd100115);
        add_req(bgc_pkg::CMD_PRESS, 3'd4, 32'd100120);
        add_req(bgc_pkg::CMD_RELEASE, 3'd4, 32'd100125);
        wait_drained();

        now_ms = 32'd200000;
        run_phase(16'd0, 16'd0, 16'd0, 1'b1, 1'b1, 60);
        run_phase(16'd65535, 16'd65535, 16'd65535, 1'b1, 1'b1, 50);
        run_phase(bgc_pkg::CFG_W'($urandom_range(0, 40)),
                  bgc_pkg::CFG_W'($urandom_range(100, 400)),
                  bgc_pkg::CFG_W'($urandom_range(200, 1500)), 1'b1, 1'b0, 60);
        run_phase(bgc_pkg::CFG_W'($urandom_range(20, 200)),
                  bgc_pkg::CFG_W'($urandom_range(200, 800)),
                  bgc_pkg::CFG_W'($urandom_range(500, 3000)), 1'b0, 1'b1, 60);
        run_phase(bgc_pkg::CFG_W'($urandom_range(0, 65535)),
                  bgc_pkg::CFG_W'($urandom_range(0, 65535)),
                  bgc_pkg::CFG_W'($urandom_range(0, 65535)), 1'b1, 1'b1, 60);
        run_phase(bgc_pkg::DEBOUNCE_RST, bgc_pkg::DOUBLE_RST, bgc_pkg::LONG_RST,
                  1'b0, 1'b0, 40);

        if (exp_gestures.size() != 0) begin
            errors++;
            $display("%0t: %0d expected gestures never arrived", $time, exp_gestures.size());
        end
        $display("%0d requests accepted over 8 timing settings", reqs_accepted);
        $display("gestures checked: %0d short, %0d long, %0d double",
                 short_seen, long_seen, double_seen);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
